FILE: rtl/core/msp_pkg.sv
// shared types, constants and helpers of the modbus server pdu engine
// no dependencies; imported by every module of the block
package msp_pkg;

  localparam int COIL_COUNT_DEF      = 2048;
  localparam int DISCRETE_COUNT_DEF  = 2048;
  localparam int HOLDING_COUNT_DEF   = 256;
  localparam int INPUT_REG_COUNT_DEF = 256;
  localparam int FRAME_MAX_DEF       = 256;

  // wide address: start + quantity without 16-bit wrap
  localparam int AW = 17;

  localparam logic [7:0] FC_RD_COILS    = 8'd1;
  localparam logic [7:0] FC_RD_DISCRETE = 8'd2;
  localparam logic [7:0] FC_RD_HOLDING  = 8'd3;
  localparam logic [7:0] FC_RD_INPUT    = 8'd4;
  localparam logic [7:0] FC_WR_COIL     = 8'd5;
  localparam logic [7:0] FC_WR_REG      = 8'd6;
  localparam logic [7:0] FC_WR_COILS    = 8'd15;
  localparam logic [7:0] FC_WR_REGS     = 8'd16;

  localparam logic [7:0] EX_FUNC  = 8'd1;
  localparam logic [7:0] EX_ADDR  = 8'd2;
  localparam logic [7:0] EX_VALUE = 8'd3;
  localparam logic [7:0] EX_FLAG  = 8'h80;

  localparam logic [15:0] QTY_RD_BITS_MAX = 16'd2000;
  localparam logic [15:0] QTY_RD_REGS_MAX = 16'd125;
  localparam logic [15:0] QTY_WR_BITS_MAX = 16'd1968;
  localparam logic [15:0] QTY_WR_REGS_MAX = 16'd123;
  localparam logic [15:0] COIL_ON         = 16'hFF00;

  typedef enum logic [1:0] {
    OP_FRAME  = 2'd0,
    OP_SET_DI = 2'd1,
    OP_SET_IR = 2'd2
  } opcode_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_HDR,
    S_CHECK,
    S_HEAD,
    S_BIT_RD,
    S_BIT_CAP,
    S_BYTE_OUT,
    S_REG_RD,
    S_REG_HI,
    S_REG_LO,
    S_WC_RD,
    S_WC_WR,
    S_WH_RDH,
    S_WH_RDL,
    S_WH_WR,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    K_EXC,
    K_ECHO,
    K_RDBIT,
    K_RDREG
  } kind_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
  } byte_chan_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic logic range_ok(input logic [15:0] a, input logic [15:0] q,
                                    input logic [AW-1:0] cnt);
    logic [AW-1:0] last_a;
    last_a = AW'(a) + AW'(q) - AW'(1);
    return (AW'(a) < cnt) && (last_a < cnt);
  endfunction

endpackage

FILE: rtl/core/modbus_server_pdu_engine.sv
// frame bytes and local updates are taken while idle; after the last the header is read and
// checked, then the response goes out: per bit read a read and a capture, per 8 bits a byte,
// per register two bytes; writes take a frame read per 8 coils or two per register; may stall
// one item at a time: no new item is taken until the response is handed to the output stage
// reset: a clearing pass over max(store sizes) addresses (2048 by default) zeroes all
// four stores before the first item; slave_address resets to 1
module modbus_server_pdu_engine #(
  parameter int COIL_COUNT      = msp_pkg::COIL_COUNT_DEF,
  parameter int DISCRETE_COUNT  = msp_pkg::DISCRETE_COUNT_DEF,
  parameter int HOLDING_COUNT   = msp_pkg::HOLDING_COUNT_DEF,
  parameter int INPUT_REG_COUNT = msp_pkg::INPUT_REG_COUNT_DEF,
  parameter int FRAME_MAX       = msp_pkg::FRAME_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_last,
  input  logic [10:0] in_local_index,
  input  logic [15:0] in_local_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte0,
  output logic [7:0]  out_byte1,
  output logic [7:0]  out_byte2,
  output logic [7:0]  out_byte3,
  output logic [2:0]  out_valid_bytes,
  output logic        out_last_of_response,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import msp_pkg::*;

  localparam int CAW = addr_w(COIL_COUNT);
  localparam int DAW = addr_w(DISCRETE_COUNT);
  localparam int HAW = addr_w(HOLDING_COUNT);
  localparam int IAW = addr_w(INPUT_REG_COUNT);
  localparam int FAW = addr_w(FRAME_MAX);
  localparam int LW  = $clog2(FRAME_MAX + 1);
  localparam int CLR_A   = (COIL_COUNT > DISCRETE_COUNT) ? COIL_COUNT : DISCRETE_COUNT;
  localparam int CLR_B   = (HOLDING_COUNT > INPUT_REG_COUNT) ? HOLDING_COUNT : INPUT_REG_COUNT;
  localparam int CLR_LEN = (CLR_A > CLR_B) ? CLR_A : CLR_B;
  localparam int CW      = addr_w(CLR_LEN);

  state_t        state_r, state_nxt;
  kind_t         kind_r, kind_nxt;
  logic [7:0]    slave_r;
  logic [LW-1:0] len_r, len_nxt;
  logic          ovf_r, ovf_nxt;
  logic [2:0]    hidx_r, hidx_nxt;
  logic [7:0]    hdr_r [7];
  logic [7:0]    hdr_nxt [7];
  logic [7:0]    exc_r, exc_nxt;
  logic [15:0]   n_r, n_nxt;
  logic [2:0]    hcnt_r, hcnt_nxt;
  logic [7:0]    pbyte_r, pbyte_nxt;
  logic [7:0]    whi_r, whi_nxt;
  logic [CW-1:0] clr_r, clr_nxt;

  logic             fb_we, fb_re;
  logic [FAW-1:0]   fb_wa, fb_ra;
  logic [7:0]       fb_wd, fb_rd;
  logic             co_we, co_re, co_wd, co_rd;
  logic [CAW-1:0]   co_wa, co_ra;
  logic             di_we, di_re, di_wd, di_rd;
  logic [DAW-1:0]   di_wa, di_ra;
  logic             ho_we, ho_re;
  logic [HAW-1:0]   ho_wa, ho_ra;
  logic [15:0]      ho_wd, ho_rd;
  logic             ir_we, ir_re;
  logic [IAW-1:0]   ir_wa, ir_ra;
  logic [15:0]      ir_wd, ir_rd;
  logic [AW-1:0]    ho_wa_wide;

  byte_chan_t bch;
  logic       bch_rdy, bacc;

  logic [7:0]    fc, bcnt;
  logic [15:0]   a, q;
  logic          bcast;
  logic [AW-1:0] ptr, nq1, clr_w, lidx_w;
  logic [LW-1:0] dlen;

  assign fc    = hdr_r[1];
  assign a     = {hdr_r[2], hdr_r[3]};
  assign q     = {hdr_r[4], hdr_r[5]};
  assign bcnt  = hdr_r[6];
  assign bcast = (hdr_r[0] == 8'd0);
  assign ptr   = AW'(a) + AW'(n_r);
  assign nq1   = AW'(n_r) + AW'(1);
  assign dlen  = len_r - LW'(2);
  assign clr_w = AW'(clr_r);
  assign lidx_w = AW'(in_local_index);
  assign bacc  = bch.vld & bch_rdy;
  assign cfg_ready = 1'b1;

  always_comb begin
    logic [AW-1:0] rbc_w;
    logic [AW-1:0] fidx;
    logic [2:0]    head_end;
    logic          nlast;
    logic          bit_v;
    logic [15:0]   rword;
    state_nxt = state_r;
    kind_nxt  = kind_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    hidx_nxt  = hidx_r;
    hdr_nxt   = hdr_r;
    exc_nxt   = exc_r;
    n_nxt     = n_r;
    hcnt_nxt  = hcnt_r;
    pbyte_nxt = pbyte_r;
    whi_nxt   = whi_r;
    clr_nxt   = clr_r;
    in_stall  = 1'b1;
    bch       = '{vld: 1'b0, data: 8'd0, last: 1'b0};
    fb_we = 1'b0; fb_wa = len_r[FAW-1:0]; fb_wd = in_frame_byte;
    fb_re = 1'b0; fb_ra = '0;
    co_we = 1'b0; co_wa = ptr[CAW-1:0]; co_wd = 1'b0;
    co_re = 1'b0; co_ra = ptr[CAW-1:0];
    di_we = 1'b0; di_wa = lidx_w[DAW-1:0]; di_wd = in_local_value[0];
    di_re = 1'b0; di_ra = ptr[DAW-1:0];
    ho_we = 1'b0; ho_wa_wide = ptr; ho_wd = q;
    ho_re = 1'b0; ho_ra = ptr[HAW-1:0];
    ir_we = 1'b0; ir_wa = lidx_w[IAW-1:0]; ir_wd = in_local_value;
    ir_re = 1'b0; ir_ra = ptr[IAW-1:0];
    rbc_w    = (AW'(q) + AW'(7)) >> 3;
    fidx     = '0;
    head_end = (kind_r == K_ECHO) ? 3'd5 : 3'd2;
    nlast    = (nq1 == AW'(q));
    bit_v    = (fc == FC_RD_COILS) ? co_rd : di_rd;
    rword    = (fc == FC_RD_HOLDING) ? ho_rd : ir_rd;

    case (state_r)
      S_CLEAR: begin
        co_we = (clr_w < AW'(COIL_COUNT));
        co_wa = clr_w[CAW-1:0];
        di_we = (clr_w < AW'(DISCRETE_COUNT));
        di_wa = clr_w[DAW-1:0];
        di_wd = 1'b0;
        ho_we = (clr_w < AW'(HOLDING_COUNT));
        ho_wa_wide = clr_w;
        ho_wd = 16'd0;
        ir_we = (clr_w < AW'(INPUT_REG_COUNT));
        ir_wa = clr_w[IAW-1:0];
        ir_wd = 16'd0;
        clr_nxt = clr_r + CW'(1);
        if (clr_r == CW'(CLR_LEN - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_opcode)
            OP_FRAME: begin
              if (len_r < LW'(FRAME_MAX)) begin
                fb_we   = 1'b1;
                len_nxt = len_r + LW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
              if (in_frame_last) begin
                hidx_nxt  = 3'd0;
                state_nxt = S_HDR;
              end
            end
            OP_SET_DI: di_we = (lidx_w < AW'(DISCRETE_COUNT));
            OP_SET_IR: ir_we = (lidx_w < AW'(INPUT_REG_COUNT));
            default: ;
          endcase
        end
      end
      S_HDR: begin
        // read bytes 0..6, each landing in the cycle after its read
        if (hidx_r != 3'd7) begin
          fb_re = 1'b1;
          fidx  = AW'(hidx_r);
          fb_ra = fidx[FAW-1:0];
        end
        if (hidx_r != 3'd0) begin
          hdr_nxt[hidx_r - 3'd1] = fb_rd;
        end
        hidx_nxt = hidx_r + 3'd1;
        if (hidx_r == 3'd7) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        n_nxt     = 16'd0;
        hcnt_nxt  = 3'd0;
        pbyte_nxt = 8'd0;
        kind_nxt  = K_EXC;
        state_nxt = bcast ? S_DONE : S_HEAD;
        if (ovf_r || len_r < LW'(2) || !(bcast || hdr_r[0] == slave_r)) begin
          state_nxt = S_DONE;
        end else if (!(fc == FC_RD_COILS || fc == FC_RD_DISCRETE ||
                       fc == FC_RD_HOLDING || fc == FC_RD_INPUT ||
                       fc == FC_WR_COIL || fc == FC_WR_REG ||
                       fc == FC_WR_COILS || fc == FC_WR_REGS)) begin
          exc_nxt = EX_FUNC;
        end else if (dlen < LW'(4) ||
                     ((fc == FC_WR_COILS || fc == FC_WR_REGS) && dlen < LW'(5))) begin
          exc_nxt = EX_VALUE;
        end else if (fc == FC_RD_COILS || fc == FC_RD_DISCRETE) begin
          if (q == 16'd0 || q > QTY_RD_BITS_MAX) begin
            exc_nxt = EX_VALUE;
          end else if (!range_ok(a, q, (fc == FC_RD_COILS) ? AW'(COIL_COUNT)
                                                            : AW'(DISCRETE_COUNT))) begin
            exc_nxt = EX_ADDR;
          end else begin
            kind_nxt = K_RDBIT;
          end
        end else if (fc == FC_RD_HOLDING || fc == FC_RD_INPUT) begin
          if (q == 16'd0 || q > QTY_RD_REGS_MAX) begin
            exc_nxt = EX_VALUE;
          end else if (!range_ok(a, q, (fc == FC_RD_HOLDING) ? AW'(HOLDING_COUNT)
                                                              : AW'(INPUT_REG_COUNT))) begin
            exc_nxt = EX_ADDR;
          end else begin
            kind_nxt = K_RDREG;
          end
        end else if (fc == FC_WR_COIL) begin
          if (q != COIL_ON && q != 16'd0) begin
            exc_nxt = EX_VALUE;
          end else if (AW'(a) >= AW'(COIL_COUNT)) begin
            exc_nxt = EX_ADDR;
          end else begin
            kind_nxt = K_ECHO;
            co_we    = 1'b1;
            co_wa    = a[CAW-1:0];
            co_wd    = (q == COIL_ON);
          end
        end else if (fc == FC_WR_REG) begin
          if (AW'(a) >= AW'(HOLDING_COUNT)) begin
            exc_nxt = EX_ADDR;
          end else begin
            kind_nxt   = K_ECHO;
            ho_we      = 1'b1;
            ho_wa_wide = AW'(a);
          end
        end else if (fc == FC_WR_COILS) begin
          if (q == 16'd0 || q > QTY_WR_BITS_MAX) begin
            exc_nxt = EX_VALUE;
          end else if (AW'(bcnt) != rbc_w) begin
            exc_nxt = EX_VALUE;
          end else if (AW'(dlen) < AW'(5) + AW'(bcnt)) begin
            exc_nxt = EX_VALUE;
          end else if (!range_ok(a, q, AW'(COIL_COUNT))) begin
            exc_nxt = EX_ADDR;
          end else begin
            kind_nxt  = K_ECHO;
            state_nxt = S_WC_RD;
          end
        end else begin
          if (q == 16'd0 || q > QTY_WR_REGS_MAX) begin
            exc_nxt = EX_VALUE;
          end else if (AW'(bcnt) != AW'({q, 1'b0})) begin
            exc_nxt = EX_VALUE;
          end else if (AW'(dlen) < AW'(5) + AW'(bcnt)) begin
            exc_nxt = EX_VALUE;
          end else if (!range_ok(a, q, AW'(HOLDING_COUNT))) begin
            exc_nxt = EX_ADDR;
          end else begin
            kind_nxt  = K_ECHO;
            state_nxt = S_WH_RDH;
          end
        end
      end
      S_HEAD: begin
        bch.vld  = 1'b1;
        bch.last = (kind_r == K_EXC || kind_r == K_ECHO) && (hcnt_r == head_end);
        case (hcnt_r)
          3'd0: bch.data = slave_r;
          3'd1: bch.data = (kind_r == K_EXC) ? (fc | EX_FLAG) : fc;
          3'd2: begin
            case (kind_r)
              K_EXC:   bch.data = exc_r;
              K_RDBIT: bch.data = rbc_w[7:0];
              K_RDREG: bch.data = {q[6:0], 1'b0};
              default: bch.data = hdr_r[2];
            endcase
          end
          3'd3: bch.data = hdr_r[3];
          3'd4: bch.data = hdr_r[4];
          3'd5: bch.data = hdr_r[5];
          default: bch.data = 8'd0;
        endcase
        if (bacc) begin
          hcnt_nxt = hcnt_r + 3'd1;
          if (hcnt_r == head_end) begin
            case (kind_r)
              K_RDBIT: state_nxt = S_BIT_RD;
              K_RDREG: state_nxt = S_REG_RD;
              default: state_nxt = S_DONE;
            endcase
          end
        end
      end
      S_BIT_RD: begin
        co_re     = (fc == FC_RD_COILS);
        di_re     = (fc != FC_RD_COILS);
        state_nxt = S_BIT_CAP;
      end
      S_BIT_CAP: begin
        pbyte_nxt[n_r[2:0]] = bit_v;
        n_nxt = n_r + 16'd1;
        state_nxt = (n_r[2:0] == 3'd7 || nlast) ? S_BYTE_OUT : S_BIT_RD;
      end
      S_BYTE_OUT: begin
        bch.vld  = 1'b1;
        bch.data = pbyte_r;
        bch.last = (AW'(n_r) == AW'(q));
        if (bacc) begin
          pbyte_nxt = 8'd0;
          state_nxt = bch.last ? S_DONE : S_BIT_RD;
        end
      end
      S_REG_RD: begin
        ho_re     = (fc == FC_RD_HOLDING);
        ir_re     = (fc != FC_RD_HOLDING);
        state_nxt = S_REG_HI;
      end
      S_REG_HI: begin
        bch.vld  = 1'b1;
        bch.data = rword[15:8];
        if (bacc) begin
          state_nxt = S_REG_LO;
        end
      end
      S_REG_LO: begin
        bch.vld  = 1'b1;
        bch.data = rword[7:0];
        bch.last = nlast;
        if (bacc) begin
          n_nxt     = n_r + 16'd1;
          state_nxt = nlast ? S_DONE : S_REG_RD;
        end
      end
      S_WC_RD: begin
        fb_re     = 1'b1;
        fidx      = AW'(7) + AW'(n_r[15:3]);
        fb_ra     = fidx[FAW-1:0];
        state_nxt = S_WC_WR;
      end
      S_WC_WR: begin
        co_we = 1'b1;
        co_wd = fb_rd[n_r[2:0]];
        n_nxt = n_r + 16'd1;
        if (nlast) begin
          state_nxt = bcast ? S_DONE : S_HEAD;
        end else if (n_r[2:0] == 3'd7) begin
          state_nxt = S_WC_RD;
        end
      end
      S_WH_RDH: begin
        fb_re     = 1'b1;
        fidx      = AW'(7) + AW'({n_r, 1'b0});
        fb_ra     = fidx[FAW-1:0];
        state_nxt = S_WH_RDL;
      end
      S_WH_RDL: begin
        whi_nxt   = fb_rd;
        fb_re     = 1'b1;
        fidx      = AW'(8) + AW'({n_r, 1'b0});
        fb_ra     = fidx[FAW-1:0];
        state_nxt = S_WH_WR;
      end
      S_WH_WR: begin
        ho_we = 1'b1;
        ho_wd = {whi_r, fb_rd};
        n_nxt = n_r + 16'd1;
        if (nlast) begin
          state_nxt = bcast ? S_DONE : S_HEAD;
        end else begin
          state_nxt = S_WH_RDH;
        end
      end
      S_DONE: begin
        len_nxt   = '0;
        ovf_nxt   = 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign ho_wa = ho_wa_wide[HAW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      slave_r <= 8'd1;
      len_r   <= '0;
      ovf_r   <= 1'b0;
      clr_r   <= '0;
      hidx_r  <= 3'd0;
      hcnt_r  <= 3'd0;
      n_r     <= 16'd0;
      kind_r  <= K_EXC;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        slave_r <= cfg_data;
      end
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      clr_r   <= clr_nxt;
      hidx_r  <= hidx_nxt;
      hcnt_r  <= hcnt_nxt;
      n_r     <= n_nxt;
      kind_r  <= kind_nxt;
    end
    hdr_r   <= hdr_nxt;
    exc_r   <= exc_nxt;
    pbyte_r <= pbyte_nxt;
    whi_r   <= whi_nxt;
  end

  msp_ram #(.DEPTH(FRAME_MAX), .WIDTH(8)) u_frame (
    .clk(clk), .we(fb_we), .wa(fb_wa), .wd(fb_wd), .re(fb_re), .ra(fb_ra), .rd(fb_rd)
  );
  msp_ram #(.DEPTH(COIL_COUNT), .WIDTH(1)) u_coil (
    .clk(clk), .we(co_we), .wa(co_wa), .wd(co_wd), .re(co_re), .ra(co_ra), .rd(co_rd)
  );
  msp_ram #(.DEPTH(DISCRETE_COUNT), .WIDTH(1)) u_disc (
    .clk(clk), .we(di_we), .wa(di_wa), .wd(di_wd), .re(di_re), .ra(di_ra), .rd(di_rd)
  );
  msp_ram #(.DEPTH(HOLDING_COUNT), .WIDTH(16)) u_hold (
    .clk(clk), .we(ho_we), .wa(ho_wa), .wd(ho_wd), .re(ho_re), .ra(ho_ra), .rd(ho_rd)
  );
  msp_ram #(.DEPTH(INPUT_REG_COUNT), .WIDTH(16)) u_inreg (
    .clk(clk), .we(ir_we), .wa(ir_wa), .wd(ir_wd), .re(ir_re), .ra(ir_ra), .rd(ir_rd)
  );

  msp_emit u_emit (
    .clk                  (clk),
    .rst_n                (rst_n),
    .bch                  (bch),
    .bch_rdy              (bch_rdy),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_byte0            (out_byte0),
    .out_byte1            (out_byte1),
    .out_byte2            (out_byte2),
    .out_byte3            (out_byte3),
    .out_valid_bytes      (out_valid_bytes),
    .out_last_of_response (out_last_of_response)
  );

`ifndef SYNTHESIS
  a_no_bytes_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !bch.vld)
    else $error("response byte during clearing pass");
  a_bit_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BIT_CAP || state_r == S_REG_LO) |-> AW'(n_r) < AW'(q))
    else $error("read walk past quantity");
  a_hold_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    ho_we |-> ho_wa_wide < AW'(HOLDING_COUNT))
    else $error("holding write out of range");
  a_no_broadcast_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HEAD) |-> !bcast)
    else $error("reply to broadcast frame");
`endif

endmodule

FILE: rtl/core/msp_ram.sv
// simple dual port ram, one write and one registered read port
// depends on msp_pkg for the address width helper
module msp_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  localparam int RAW  = msp_pkg::addr_w(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [RAW-1:0]   wa,
  input  logic [WIDTH-1:0] wd,
  input  logic             re,
  input  logic [RAW-1:0]   ra,
  output logic [WIDTH-1:0] rd
);
  import msp_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule

FILE: rtl/core/msp_emit.sv
// packs response bytes into 4-lane items and holds them in the output register
// depends on msp_pkg for the byte channel struct
module msp_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  msp_pkg::byte_chan_t bch,
  output logic               bch_rdy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte0,
  output logic [7:0]         out_byte1,
  output logic [7:0]         out_byte2,
  output logic [7:0]         out_byte3,
  output logic [2:0]         out_valid_bytes,
  output logic               out_last_of_response
);
  import msp_pkg::*;

  logic [7:0] acc_r [4];
  logic [7:0] acc_nxt [4];
  logic [2:0] cnt_r, cnt_nxt;
  logic       pend_r, pend_nxt;
  logic       plast_r, plast_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r [4];
  logic [7:0] ob_nxt [4];
  logic [2:0] on_r, on_nxt;
  logic       ol_r, ol_nxt;
  logic       take, free;

  assign take    = ov_r & ~out_stall;
  assign free    = ~ov_r | take;
  assign bch_rdy = ~pend_r;

  always_comb begin
    logic [7:0] lanes [4];
    logic [2:0] ncnt;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    plast_nxt = plast_r;
    ob_nxt    = ob_r;
    on_nxt    = on_r;
    ol_nxt    = ol_r;
    ov_nxt    = ov_r & ~take;
    lanes     = acc_r;
    lanes[cnt_r[1:0]] = bch.data;
    ncnt      = cnt_r + 3'd1;
    if (pend_r) begin
      if (free) begin
        ob_nxt   = acc_r;
        on_nxt   = cnt_r;
        ol_nxt   = plast_r;
        ov_nxt   = 1'b1;
        acc_nxt  = '{default: 8'd0};
        cnt_nxt  = 3'd0;
        pend_nxt = 1'b0;
      end
    end else if (bch.vld) begin
      if (ncnt == 3'd4 || bch.last) begin
        if (free) begin
          ob_nxt  = lanes;
          on_nxt  = ncnt;
          ol_nxt  = bch.last;
          ov_nxt  = 1'b1;
          acc_nxt = '{default: 8'd0};
          cnt_nxt = 3'd0;
        end else begin
          acc_nxt   = lanes;
          cnt_nxt   = ncnt;
          pend_nxt  = 1'b1;
          plast_nxt = bch.last;
        end
      end else begin
        acc_nxt = lanes;
        cnt_nxt = ncnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '{default: 8'd0};
      cnt_r   <= 3'd0;
      pend_r  <= 1'b0;
      plast_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      plast_r <= plast_nxt;
      ov_r    <= ov_nxt;
    end
    ob_r <= ob_nxt;
    on_r <= on_nxt;
    ol_r <= ol_nxt;
  end

  assign out_valid            = ov_r;
  assign out_byte0            = ob_r[0];
  assign out_byte1            = ob_r[1];
  assign out_byte2            = ob_r[2];
  assign out_byte3            = ob_r[3];
  assign out_valid_bytes      = on_r;
  assign out_last_of_response = ol_r;

`ifndef SYNTHESIS
  a_lane_count: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (on_r != 3'd0 && on_r <= 3'd4))
    else $error("item with bad lane count");
  a_full_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !ol_r) |-> on_r == 3'd4)
    else $error("non-final item not full");
  a_pend_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> cnt_r != 3'd0)
    else $error("pending item with no bytes");
`endif

endmodule
